// ===== rtl/core/adcrb_pkg.sv =====
package adcrb_pkg;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NOP   = 2'd3
  } act_e;

  localparam int unsigned PACKET_BYTES = 8192;
  localparam logic [31:0] PKT_LEN = 32'(PACKET_BYTES);

  // register offsets, low two bits cleared
  localparam logic [15:0] OFF_CTRL   = 16'h0000;
  localparam logic [15:0] OFF_STATUS = 16'h0004;
  localparam logic [15:0] OFF_UART   = 16'h0008;
  localparam logic [15:0] OFF_PAGE   = 16'h000c;
  localparam logic [15:0] OFF_CODEC  = 16'h0010;
  localparam logic [15:0] OFF_SCTRL  = 16'h0020;
  localparam logic [15:0] OFF_SCNT0  = 16'h0024;
  localparam logic [15:0] OFF_SCNT1  = 16'h0028;
  localparam logic [15:0] OFF_SCNT2  = 16'h002c;
  localparam logic [15:0] OFF_FA0    = 16'h0c30;
  localparam logic [15:0] OFF_FC0    = 16'h0c34;
  localparam logic [15:0] OFF_FA1    = 16'h0c38;
  localparam logic [15:0] OFF_FC1    = 16'h0c3c;
  localparam logic [15:0] OFF_FA2    = 16'h0d30;
  localparam logic [15:0] OFF_FC2    = 16'h0d34;
  localparam logic [15:0] PAGED_BASE = 16'h0030;
  localparam logic [15:0] OFF_MASK   = 16'hfffc;

  localparam logic [31:0] IRQ_BIT      = 32'h8000_0000;
  localparam logic [31:0] CTRL_RESET   = 32'h0000_0001;
  localparam logic [31:0] STATUS_RESET = 32'h0000_0060;

  // sample rate of the second dac and the adc is RATE_NUM / (field + 2)
  localparam logic [20:0] RATE_NUM   = 21'd1411200;
  localparam logic [20:0] RATE_RESET = 21'd705600;
  localparam logic [4:0]  DIV_LAST   = 5'd20;

  typedef struct packed {
    act_e        act;
    logic [15:0] offset;
    logic        paged;
    logic [31:0] data;
    logic [2:0]  bytes;
    logic [1:0]  ch;
  } item_t;

endpackage

// ===== rtl/core/adcrb_if.sv =====
interface adcrb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] port_address;
  logic [31:0] write_data;
  logic [2:0]  access_bytes;
  logic [1:0]  tick_channel;

  modport source(output valid, action, port_address, write_data, access_bytes, tick_channel,
                 input ready);
  modport sink(input valid, action, port_address, write_data, access_bytes, tick_channel,
               output ready);
endinterface

interface adcrb_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_level;
  logic        dma_valid;
  logic        dma_to_memory;
  logic [31:0] dma_address;
  logic [13:0] dma_length;

  modport source(output valid, read_data, irq_level, dma_valid, dma_to_memory, dma_address,
                 dma_length, input ready);
  modport sink(input valid, read_data, irq_level, dma_valid, dma_to_memory, dma_address,
               dma_length, output ready);
endinterface

// ===== rtl/core/adcrb_front.sv =====
module adcrb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  adcrb_req_if.sink           req_i,
  input  logic                pop_i,
  output logic                head_vld_o,
  output adcrb_pkg::item_t    head_o
);

  logic [15:0]      base_q;
  adcrb_pkg::item_t cls;
  adcrb_pkg::item_t buf_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  // classify the incoming word
  always_comb begin
    cls.act    = adcrb_pkg::act_e'(req_i.action);
    cls.offset = req_i.port_address - base_q;
    cls.paged  = cls.offset >= adcrb_pkg::PAGED_BASE;
    cls.data   = req_i.write_data;
    cls.bytes  = (req_i.access_bytes > 3'd4) ? 3'd4 : req_i.access_bytes;
    cls.ch     = (req_i.tick_channel == 2'd3) ? 2'd2 : req_i.tick_channel;
  end

  assign req_i.ready = cnt_q != 2'd2;
  assign push        = req_i.valid && req_i.ready;
  assign pop         = pop_i && (cnt_q != 2'd0);
  assign head_vld_o  = cnt_q != 2'd0;
  assign head_o      = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== rtl/core/adcrb_back.sv =====
module adcrb_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_vld_i,
  input  adcrb_pkg::item_t head_i,
  output logic             pop_o,
  adcrb_rsp_if.source      rsp_o
);

  function automatic logic [31:0] set_status(logic [31:0] cur, logic [31:0] ns);
    logic [31:0] r;
    if (ns == cur) begin
      r = cur;
    end else if (|ns[2:0]) begin
      r = ns | adcrb_pkg::IRQ_BIT;
    end else begin
      r = ns & ~adcrb_pkg::IRQ_BIT;
    end
    return r;
  endfunction

  function automatic logic [1:0] shift_of(logic [1:0] fmt);
    return {1'b0, fmt[0]} + {1'b0, fmt[1]};
  endfunction

  function automatic logic [4:0] DIV_IDX(logic [4:0] c);
    return adcrb_pkg::DIV_LAST - c;
  endfunction

  // architectural state
  logic [31:0] ctl_q, ctl_d, stat_q, stat_d, sctl_q, sctl_d;
  logic [3:0]  page_q, page_d;
  logic [15:0] codec_q, codec_d;
  logic [31:0] scnt_q [3], scnt_d [3];
  logic [1:0]  left_q [3], left_d [3];
  logic [31:0] fa_q [3], fa_d [3];
  logic [31:0] fc_q [3], fc_d [3];
  logic [1:0]  shift_q [3], shift_d [3];
  logic [20:0] rate_q, rate_d;

  // rate divider
  logic        div_busy_q, div_busy_d, div_done_q, div_done_d;
  logic [4:0]  div_cnt_q, div_cnt_d;
  logic [13:0] div_rem_q, div_rem_d, div_den_q, div_den_d;
  logic [20:0] div_quo_q, div_quo_d;
  logic [14:0] rem_sh;
  logic        rem_ge;

  // output register
  logic        out_vld_q, out_vld_d;
  logic [31:0] o_rd_d, o_addr_d;
  logic        o_irq_d, o_dv_d, o_mem_d;
  logic [13:0] o_len_d;

  // decode
  logic [15:0] off, reg_off;
  logic [4:0]  bsh;
  logic [31:0] bmask, wval, nv_ctl, nv_sctl, rd_val;
  logic        need_div, go, out_space;

  // tick datapath
  logic [1:0]  tc, sh, lo;
  logic [31:0] csc, cnt32, size32, left, len, moved, addr, mlo, csc_rem, cnt_new;
  logic        en, pause, loop, done;

  assign off     = head_i.offset | (head_i.paged ? {4'b0, page_q, 8'b0} : 16'h0000);
  assign reg_off = off & adcrb_pkg::OFF_MASK;
  assign bsh     = {off[1:0], 3'b000};

  always_comb begin
    case (head_i.bytes)
      3'd0:    bmask = 32'h0000_0000;
      3'd1:    bmask = 32'h0000_00ff;
      3'd2:    bmask = 32'h0000_ffff;
      3'd3:    bmask = 32'h00ff_ffff;
      default: bmask = 32'hffff_ffff;
    endcase
    bmask = bmask << bsh;
  end

  assign wval    = (head_i.data << bsh) & bmask;
  assign nv_ctl  = (ctl_q & ~bmask) | wval;
  assign nv_sctl = (sctl_q & ~bmask) | wval;

  // a control write that moves the rate field waits for the divider
  assign need_div  = head_i.act == adcrb_pkg::ACT_WRITE && reg_off == adcrb_pkg::OFF_CTRL
                     && nv_ctl[28:16] != ctl_q[28:16];
  assign out_space = !out_vld_q || rsp_o.ready;
  assign go        = head_vld_i && out_space && !div_busy_q && (!need_div || div_done_q);
  assign pop_o     = go;

  assign rem_sh = {div_rem_q, adcrb_pkg::RATE_NUM[DIV_IDX(div_cnt_q)]};
  assign rem_ge = rem_sh >= {1'b0, div_den_q};

  // register read
  always_comb begin
    unique case (reg_off)
      adcrb_pkg::OFF_CTRL:   rd_val = ctl_q >> bsh;
      adcrb_pkg::OFF_STATUS: rd_val = stat_q >> bsh;
      adcrb_pkg::OFF_UART:   rd_val = 32'h0;
      adcrb_pkg::OFF_PAGE:   rd_val = {28'h0, page_q};
      adcrb_pkg::OFF_CODEC:  rd_val = {16'h0, codec_q};
      adcrb_pkg::OFF_SCTRL:  rd_val = sctl_q >> bsh;
      adcrb_pkg::OFF_SCNT0:  rd_val = scnt_q[0] >> bsh;
      adcrb_pkg::OFF_SCNT1:  rd_val = scnt_q[1] >> bsh;
      adcrb_pkg::OFF_SCNT2:  rd_val = scnt_q[2] >> bsh;
      adcrb_pkg::OFF_FA0:    rd_val = fa_q[0];
      adcrb_pkg::OFF_FC0:    rd_val = fc_q[0];
      adcrb_pkg::OFF_FA1:    rd_val = fa_q[1];
      adcrb_pkg::OFF_FC1:    rd_val = fc_q[1];
      adcrb_pkg::OFF_FA2:    rd_val = fa_q[2];
      adcrb_pkg::OFF_FC2:    rd_val = fc_q[2];
      default:               rd_val = 32'hffff_ffff;
    endcase
  end

  // tick datapath
  always_comb begin
    tc     = head_i.ch;
    sh     = shift_q[tc];
    lo     = left_q[tc];
    en     = (tc == 2'd0) ? ctl_q[6] : (tc == 2'd1) ? ctl_q[5] : ctl_q[4];
    pause  = (tc == 2'd0) ? sctl_q[11] : (tc == 2'd1) ? sctl_q[12] : 1'b0;
    loop   = (tc == 2'd0) ? sctl_q[13] : (tc == 2'd1) ? sctl_q[14] : sctl_q[15];
    csc    = ({16'h0, scnt_q[tc][31:16]} + 32'd1) << sh;
    cnt32  = {16'h0, fc_q[tc][31:16]};
    size32 = {16'h0, fc_q[tc][15:0]};
    left   = ((size32 - cnt32 + 32'd1) << 2) + {30'h0, lo};
    len    = adcrb_pkg::PKT_LEN;
    if (left < len) begin
      len = left;
    end
    if (csc < len) begin
      len = csc;
    end
    moved   = (tc == 2'd2) ? adcrb_pkg::PKT_LEN : len;
    addr    = fa_q[tc] + (cnt32 << 2) + {30'h0, lo};
    done    = csc == moved;
    mlo     = moved + {30'h0, lo};
    csc_rem = (csc - moved - 32'd1) >> sh;
    cnt_new = cnt32 + (mlo >> 2);
  end

  always_comb begin
    logic [31:0] ns;
    ctl_d   = ctl_q;
    stat_d  = stat_q;
    sctl_d  = sctl_q;
    page_d  = page_q;
    codec_d = codec_q;
    scnt_d  = scnt_q;
    left_d  = left_q;
    fa_d    = fa_q;
    fc_d    = fc_q;
    shift_d = shift_q;
    rate_d  = rate_q;
    ns      = stat_q;

    div_busy_d = div_busy_q;
    div_done_d = div_done_q;
    div_cnt_d  = div_cnt_q;
    div_rem_d  = div_rem_q;
    div_den_d  = div_den_q;
    div_quo_d  = div_quo_q;

    out_vld_d = out_vld_q && !rsp_o.ready;
    o_rd_d    = 32'h0;
    o_dv_d    = 1'b0;
    o_mem_d   = 1'b0;
    o_addr_d  = 32'h0;
    o_len_d   = 14'h0;

    // restoring divider, one quotient bit per cycle
    if (div_busy_q) begin
      div_rem_d = rem_ge ? 14'(rem_sh - {1'b0, div_den_q}) : rem_sh[13:0];
      div_quo_d = {div_quo_q[19:0], rem_ge};
      if (div_cnt_q == adcrb_pkg::DIV_LAST) begin
        div_busy_d = 1'b0;
        div_done_d = 1'b1;
      end else begin
        div_cnt_d = div_cnt_q + 5'd1;
      end
    end else if (head_vld_i && need_div && !div_done_q) begin
      div_busy_d = 1'b1;
      div_cnt_d  = '0;
      div_rem_d  = '0;
      div_quo_d  = '0;
      div_den_d  = 14'(nv_ctl[28:16]) + 14'd2;
    end

    if (go) begin
      out_vld_d = 1'b1;
      case (head_i.act)
        adcrb_pkg::ACT_READ: begin
          o_rd_d = rd_val;
        end
        adcrb_pkg::ACT_WRITE: begin
          unique case (reg_off)
            adcrb_pkg::OFF_CTRL: begin
              if (ctl_q[13:12] != nv_ctl[13:12]) begin
                shift_d[0] = shift_of(sctl_q[1:0]);
              end
              if (need_div) begin
                div_done_d = 1'b0;
                rate_d     = div_quo_q;
                if (div_quo_q != rate_q) begin
                  shift_d[1] = shift_of(sctl_q[3:2]);
                  shift_d[2] = shift_of(sctl_q[5:4]);
                end
              end
              ctl_d = nv_ctl;
            end
            adcrb_pkg::OFF_PAGE:  page_d  = head_i.data[3:0];
            adcrb_pkg::OFF_CODEC: codec_d = head_i.data[15:0];
            adcrb_pkg::OFF_SCTRL: begin
              // a falling interrupt enable drops that channel's status bit
              if (!nv_sctl[8] && sctl_q[8]) ns[2] = 1'b0;
              if (!nv_sctl[9] && sctl_q[9]) ns[1] = 1'b0;
              if (!nv_sctl[10] && sctl_q[10]) ns[0] = 1'b0;
              stat_d = set_status(stat_q, ns);
              for (int c = 0; c < 3; c++) begin
                if (nv_sctl[2*c +: 2] != sctl_q[2*c +: 2]) begin
                  shift_d[c] = shift_of(nv_sctl[2*c +: 2]);
                end
              end
              sctl_d = nv_sctl;
            end
            adcrb_pkg::OFF_SCNT0: scnt_d[0] = {head_i.data[15:0], head_i.data[15:0]};
            adcrb_pkg::OFF_SCNT1: scnt_d[1] = {head_i.data[15:0], head_i.data[15:0]};
            adcrb_pkg::OFF_SCNT2: scnt_d[2] = {head_i.data[15:0], head_i.data[15:0]};
            adcrb_pkg::OFF_FA0:   fa_d[0] = head_i.data;
            adcrb_pkg::OFF_FC0:   fc_d[0] = head_i.data;
            adcrb_pkg::OFF_FA1:   fa_d[1] = head_i.data;
            adcrb_pkg::OFF_FC1:   fc_d[1] = head_i.data;
            adcrb_pkg::OFF_FA2:   fa_d[2] = head_i.data;
            adcrb_pkg::OFF_FC2:   fc_d[2] = head_i.data;
            default: ;
          endcase
        end
        adcrb_pkg::ACT_TICK: begin
          if (en && !pause) begin
            o_dv_d   = 1'b1;
            o_mem_d  = tc == 2'd2;
            o_addr_d = addr;
            o_len_d  = moved[13:0];
            scnt_d[tc] = done ? {scnt_q[tc][15:0], scnt_q[tc][15:0]}
                              : {csc_rem[15:0], scnt_q[tc][15:0]};
            if (!loop) begin
              fc_d[tc] = (cnt_new <= size32) ? {cnt_new[15:0], size32[15:0]}
                                             : {16'h0, size32[15:0]};
            end
            left_d[tc] = mlo[1:0];
            if (done && sctl_q[8 + 32'(tc)]) begin
              ns[2 - 32'(tc)] = 1'b1;
            end
            stat_d = set_status(stat_q, ns);
          end
        end
        default: ;
      endcase
      o_irq_d = stat_d[31];
    end else begin
      o_irq_d = stat_q[31];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q      <= adcrb_pkg::CTRL_RESET;
      stat_q     <= adcrb_pkg::STATUS_RESET;
      sctl_q     <= '0;
      page_q     <= '0;
      codec_q    <= '0;
      rate_q     <= adcrb_pkg::RATE_RESET;
      div_busy_q <= 1'b0;
      div_done_q <= 1'b0;
      div_cnt_q  <= '0;
      out_vld_q  <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        scnt_q[c]  <= '0;
        left_q[c]  <= '0;
        fa_q[c]    <= '0;
        fc_q[c]    <= '0;
        shift_q[c] <= '0;
      end
    end else begin
      ctl_q      <= ctl_d;
      stat_q     <= stat_d;
      sctl_q     <= sctl_d;
      page_q     <= page_d;
      codec_q    <= codec_d;
      rate_q     <= rate_d;
      div_busy_q <= div_busy_d;
      div_done_q <= div_done_d;
      div_cnt_q  <= div_cnt_d;
      out_vld_q  <= out_vld_d;
      scnt_q     <= scnt_d;
      left_q     <= left_d;
      fa_q       <= fa_d;
      fc_q       <= fc_d;
      shift_q    <= shift_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_rem_q <= div_rem_d;
    div_den_q <= div_den_d;
    div_quo_q <= div_quo_d;
    if (go) begin
      rsp_o.read_data     <= o_rd_d;
      rsp_o.irq_level     <= o_irq_d;
      rsp_o.dma_valid     <= o_dv_d;
      rsp_o.dma_to_memory <= o_mem_d;
      rsp_o.dma_address   <= o_addr_d;
      rsp_o.dma_length    <= o_len_d;
    end
  end

  assign rsp_o.valid = out_vld_q;

endmodule

// ===== rtl/core/audio_dma_channel_register_block.sv =====
// path: a word waits in the front queue, then moves into the output register
// throughput: one word per cycle unless the output stalls; a control write changing
//   the rate field holds the back end while the divider finds one quotient bit a cycle
// reset (rst_ni low, asynchronous): control 1, status 0x60, base, page, codec,
//   serial control and all channel state cleared, queue and output empty
module audio_dma_channel_register_block (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  adcrb_req_if.sink   req_i,
  adcrb_rsp_if.source rsp_o
);

  // front to back: queue head and pop
  logic             head_vld;
  adcrb_pkg::item_t head;
  logic             pop;

  // front: base register, offset decode, two-word queue
  adcrb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .pop_i       (pop),
    .head_vld_o  (head_vld),
    .head_o      (head)
  );

  // back: register file, tick engine, rate divider, output register
  adcrb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_vld_i (head_vld),
    .head_i     (head),
    .pop_o      (pop),
    .rsp_o      (rsp_o)
  );

endmodule

// ===== tb/adcrb_checker.sv =====
`timescale 1ns / 100ps

module adcrb_checker
  import adcrb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  adcrb_req_if        req,
  adcrb_rsp_if        rsp,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] rdata;
    logic        irq;
    logic        dma;
    logic        to_mem;
    logic [31:0] addr;
    logic [13:0] len;
  } bus_result_t;

  localparam logic [31:0] SCTRL_IE_MASK = 32'h0000_0100;
  localparam logic [31:0] LOW_HALF      = 32'h0000_ffff;

  logic [15:0] io_base;
  logic [31:0] ctrl, status, sctrl;
  logic [3:0]  page;
  logic [15:0] codec;
  logic [31:0] samples [3];
  logic [31:0] buf_base [3];
  logic [31:0] buf_count [3];
  logic [1:0]  leftover [3];
  logic [1:0]  shift [3];

  bus_result_t expected_words [$];

  function automatic logic [31:0] enable_of(int c);
    case (c)
      0: return 32'h0040;
      1: return 32'h0020;
      default: return 32'h0010;
    endcase
  endfunction

  function automatic logic [31:0] pause_of(int c);
    case (c)
      0: return 32'h0800;
      1: return 32'h1000;
      default: return 32'h0000;
    endcase
  endfunction

  function automatic logic [31:0] loop_of(int c);
    case (c)
      0: return 32'h2000;
      1: return 32'h4000;
      default: return 32'h8000;
    endcase
  endfunction

  function automatic logic [31:0] rate_hz(logic [31:0] c, int ch);
    if (ch == 0) begin
      case (c[13:12])
        2'd0: return 32'd5512;
        2'd1: return 32'd11025;
        2'd2: return 32'd22050;
        default: return 32'd44100;
      endcase
    end
    return 32'd1411200 / ({19'd0, c[28:16]} + 32'd2);
  endfunction

  // format or rate change recomputes the bytes-per-sample shift
  function automatic void load_voices(logic [31:0] c, logic [31:0] s);
    logic [1:0] of, nf;
    for (int ch = 0; ch < 3; ch++) begin
      of = sctrl[ch*2 +: 2];
      nf = s[ch*2 +: 2];
      if (of != nf || rate_hz(ctrl, ch) != rate_hz(c, ch))
        shift[ch] = {1'b0, nf[0]} + {1'b0, nf[1]};
    end
    ctrl = c;
    sctrl = s;
  endfunction

  function automatic void load_status(logic [31:0] ns);
    if (ns == status) return;
    if (ns[2:0] != 0) status = ns | IRQ_BIT;
    else status = ns & ~IRQ_BIT;
  endfunction

  function automatic logic [15:0] offset_of(logic [15:0] port);
    logic [15:0] off;
    off = port - io_base;
    if (off >= PAGED_BASE) off = off | {4'd0, page, 8'd0};
    return off;
  endfunction

  function automatic logic [31:0] read_reg(logic [15:0] off);
    int sh;
    sh = off[1:0] * 8;
    case (off & OFF_MASK)
      OFF_CTRL:   return ctrl >> sh;
      OFF_STATUS: return status >> sh;
      OFF_UART:   return 32'd0;
      OFF_PAGE:   return {28'd0, page};
      OFF_CODEC:  return {16'd0, codec};
      OFF_SCTRL:  return sctrl >> sh;
      OFF_SCNT0:  return samples[0] >> sh;
      OFF_SCNT1:  return samples[1] >> sh;
      OFF_SCNT2:  return samples[2] >> sh;
      OFF_FA0:    return buf_base[0];
      OFF_FC0:    return buf_count[0];
      OFF_FA1:    return buf_base[1];
      OFF_FC1:    return buf_count[1];
      OFF_FA2:    return buf_base[2];
      OFF_FC2:    return buf_count[2];
      default:    return 32'hffff_ffff;
    endcase
  endfunction

  function automatic void write_reg(logic [15:0] off, logic [31:0] v, logic [2:0] bytes);
    int sh, b;
    logic [31:0] m, nv, ns;
    sh = off[1:0] * 8;
    b = (bytes > 4) ? 4 : bytes;
    m = (b == 0) ? 32'd0 : ((32'hffff_ffff >> ((4 - b) * 8)) << sh);
    case (off & OFF_MASK)
      OFF_CTRL: begin
        nv = (ctrl & ~m) | ((v << sh) & m);
        load_voices(nv, sctrl);
      end
      OFF_PAGE:  page = v[3:0];
      OFF_CODEC: codec = v[15:0];
      OFF_SCTRL: begin
        nv = (sctrl & ~m) | ((v << sh) & m);
        ns = status;
        // a falling interrupt enable drops that channel's status bit
        for (int c = 0; c < 3; c++)
          if (!(nv & (SCTRL_IE_MASK << c)) && (sctrl & (SCTRL_IE_MASK << c)))
            ns = ns & ~(32'd4 >> c);
        load_status(ns);
        load_voices(ctrl, nv);
      end
      OFF_SCNT0: samples[0] = {v[15:0], v[15:0]};
      OFF_SCNT1: samples[1] = {v[15:0], v[15:0]};
      OFF_SCNT2: samples[2] = {v[15:0], v[15:0]};
      OFF_FA0: buf_base[0] = v;
      OFF_FC0: buf_count[0] = v;
      OFF_FA1: buf_base[1] = v;
      OFF_FC1: buf_count[1] = v;
      OFF_FA2: buf_base[2] = v;
      OFF_FC2: buf_count[2] = v;
      default: ;
    endcase
  endfunction

  function automatic void run_tick(int c, inout bus_result_t r);
    int sh;
    logic [31:0] lo, sc, csc, cnt, size, left, len, addr, moved, ns;
    logic done;
    sh = shift[c];
    lo = {30'd0, leftover[c]};
    if (!(ctrl & enable_of(c)) || (sctrl & pause_of(c))) return;
    sc = samples[c] & LOW_HALF;
    csc = ((samples[c] >> 16) + 32'd1) << sh;
    cnt = buf_count[c] >> 16;
    size = buf_count[c] & LOW_HALF;
    left = ((size - cnt + 32'd1) << 2) + lo;
    len = PKT_LEN;
    if (left < len) len = left;
    if (csc < len) len = csc;
    addr = buf_base[c] + (cnt << 2) + lo;
    moved = (c == 2) ? PKT_LEN : len;
    r.dma = 1'b1;
    r.to_mem = (c == 2);
    r.addr = addr;
    r.len = moved[13:0];
    done = (csc == moved);
    if (done) samples[c] = sc | (sc << 16);
    else samples[c] = sc | (((csc - moved - 32'd1) >> sh) << 16);
    cnt = cnt + ((moved + lo) >> 2);
    if (!(sctrl & loop_of(c))) begin
      buf_count[c] = size;
      if (cnt <= size) buf_count[c] = buf_count[c] | (cnt << 16);
    end
    leftover[c] = moved[1:0] + lo[1:0];
    ns = status;
    if (done && (sctrl & (SCTRL_IE_MASK << c))) ns = ns | (32'd4 >> c);
    load_status(ns);
  endfunction

  function automatic bus_result_t predict_word(act_e a, logic [15:0] port, logic [31:0] d,
                                               logic [2:0] bytes, logic [1:0] ch);
    bus_result_t r;
    r = '0;
    case (a)
      ACT_READ:  r.rdata = read_reg(offset_of(port));
      ACT_WRITE: write_reg(offset_of(port), d, bytes);
      ACT_TICK:  run_tick((ch > 2) ? 2 : ch, r);
      default: ;
    endcase
    r.irq = status[31];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bus_result_t e, got;
    if (!rst_ni) begin
      io_base = '0;
      ctrl = CTRL_RESET;
      status = STATUS_RESET;
      page = '0;
      codec = '0;
      sctrl = '0;
      for (int c = 0; c < 3; c++) begin
        samples[c] = '0;
        buf_base[c] = '0;
        buf_count[c] = '0;
        leftover[c] = '0;
        shift[c] = '0;
      end
      expected_words.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) io_base = cfg_wdata_i;
      if (req.valid && req.ready)
        expected_words.push_back(predict_word(act_e'(req.action), req.port_address,
                                              req.write_data, req.access_bytes,
                                              req.tick_channel));
      if (rsp.valid && rsp.ready) begin
        got = {rsp.read_data, rsp.irq_level, rsp.dma_valid, rsp.dma_to_memory,
               rsp.dma_address, rsp.dma_length};
        if (expected_words.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected word: %h", got);
        end else begin
          e = expected_words.pop_front();
          if (got !== e) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch rd %h/%h irq %b/%b dma %b/%b mem %b/%b addr %h/%h len %0d/%0d",
                       e.rdata, got.rdata, e.irq, got.irq, e.dma, got.dma, e.to_mem,
                       got.to_mem, e.addr, got.addr, e.len, got.len);
          end
        end
      end
    end
    pending_o = expected_words.size();
  end

endmodule

// ===== tb/audio_dma_channel_register_block_tb.sv =====
`timescale 1ns / 100ps

module audio_dma_channel_register_block_tb;
  import adcrb_pkg::*;

  // tick channels
  localparam logic [1:0] CH_DAC1 = 2'd0;
  localparam logic [1:0] CH_DAC2 = 2'd1;
  localparam logic [1:0] CH_ADC  = 2'd2;
  localparam logic [1:0] CH_ALIAS = 2'd3;
  // frame registers as seen before paging, and the pages that reach them
  localparam logic [15:0] WIN_ADDR_A = PAGED_BASE;
  localparam logic [15:0] WIN_CNT_A  = PAGED_BASE + 16'd4;
  localparam logic [15:0] WIN_ADDR_B = PAGED_BASE + 16'd8;
  localparam logic [15:0] WIN_CNT_B  = PAGED_BASE + 16'd12;
  localparam logic [3:0]  PAGE_DAC   = OFF_FA0[11:8];
  localparam logic [3:0]  PAGE_ADC   = OFF_FA2[11:8];
  localparam logic [15:0] OFF_HOLE   = 16'h0014;
  localparam int          WORDS_PER_PHASE = 440;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic [15:0] io_base;
  logic        calm;
  int          fail_count;
  int          pending;

  adcrb_req_if req ();
  adcrb_rsp_if rsp ();

  audio_dma_channel_register_block dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req),
    .rsp_o      (rsp)
  );

  adcrb_checker scoreboard (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req         (req),
    .rsp         (rsp),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // generous ceiling; a healthy run ends far earlier
  initial begin
    #4ms;
    $display("FAILURE");
    $finish;
  end

  // response side stalls in random bursts until the calm tail
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      rsp.ready <= 1'b1;
    end
  end

  // one word onto the request channel; returns at the edge that takes it
  task automatic send_word(act_e a, logic [15:0] port, logic [31:0] d, logic [2:0] bytes,
                           logic [1:0] ch);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.action       <= a;
    req.port_address <= port;
    req.write_data   <= d;
    req.access_bytes <= bytes;
    req.tick_channel <= ch;
    // ready is settled by the falling edge, so the next rising edge decides
    @(negedge clk);
    while (!req.ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic reg_read(logic [15:0] off);
    send_word(ACT_READ, io_base + off, $urandom, 3'($urandom_range(0, 7)),
              2'($urandom_range(0, 3)));
  endtask

  task automatic reg_write(logic [15:0] off, logic [31:0] d, logic [2:0] bytes);
    send_word(ACT_WRITE, io_base + off, d, bytes, 2'($urandom_range(0, 3)));
  endtask

  task automatic tick(logic [1:0] ch);
    send_word(ACT_TICK, 16'($urandom), $urandom, 3'($urandom_range(0, 7)), ch);
  endtask

  // new port base, written only with nothing in flight
  task automatic move_base(logic [15:0] b);
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= b;
    io_base   <= b;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [15:0] any_offset();
    logic [15:0] list [13];
    list = '{OFF_CTRL, OFF_STATUS, OFF_UART, OFF_PAGE, OFF_CODEC, OFF_SCTRL, OFF_SCNT0,
             OFF_SCNT1, OFF_SCNT2, WIN_ADDR_A, WIN_CNT_A, WIN_ADDR_B, WIN_CNT_B};
    return list[$urandom_range(0, 12)] | 16'($urandom_range(0, 3));
  endfunction

  function automatic logic [2:0] some_bytes();
    return ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
  endfunction

  // mostly well-formed channel setup and ticks, with noise
  task automatic random_word();
    int r;
    logic [31:0] d;
    logic [15:0] size;
    r = $urandom_range(0, 99);
    if (r < 38) begin
      tick(2'($urandom_range(0, 3)));
    end else if (r < 52) begin
      reg_read(any_offset());
    end else if (r < 88) begin
      case ($urandom_range(0, 7))
        0: begin
          // keep channels enabled most of the time; rate field changes stall the block
          d = $urandom;
          if ($urandom_range(0, 2) != 0) d = d | 32'h70;
          if ($urandom_range(0, 3) != 0) d = (d & 32'h0000_ffff) | 32'h000b_0000;
          reg_write(OFF_CTRL, d, some_bytes());
        end
        1: begin
          d = $urandom;
          if ($urandom_range(0, 3) != 0) d = d & ~32'h1800;
          if ($urandom_range(0, 1) != 0) d = d & 32'h0000_ffff;
          reg_write(OFF_SCTRL, d, some_bytes());
        end
        2: reg_write(OFF_PAGE, ($urandom_range(0, 3) == 0) ? $urandom :
                     {28'd0, ($urandom_range(0, 1) != 0) ? PAGE_DAC : PAGE_ADC}, some_bytes());
        3: reg_write(OFF_CODEC, $urandom, some_bytes());
        4: reg_write(OFF_SCNT0 + 16'(4 * $urandom_range(0, 2)),
                     ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40),
                     some_bytes());
        5: reg_write(($urandom_range(0, 1) != 0) ? WIN_ADDR_A : WIN_ADDR_B, $urandom, 3'd4);
        6: begin
          size = 16'($urandom_range(0, 20));
          d = {16'($urandom_range(0, size + 1)), size};
          if ($urandom_range(0, 4) == 0) d = $urandom;
          reg_write(($urandom_range(0, 1) != 0) ? WIN_CNT_A : WIN_CNT_B, d, 3'd4);
        end
        default: send_word(ACT_WRITE, 16'($urandom), $urandom, 3'($urandom_range(0, 7)),
                           2'($urandom_range(0, 3)));
      endcase
    end else if (r < 94) begin
      send_word(ACT_NOP, 16'($urandom), $urandom, 3'($urandom_range(0, 7)),
                2'($urandom_range(0, 3)));
    end else begin
      send_word(ACT_READ, 16'($urandom), $urandom, 3'($urandom_range(0, 7)),
                2'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    logic [15:0] bases [4];
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    io_base          <= '0;
    calm             <= 1'b0;
    req.valid        <= 1'b0;
    req.action       <= ACT_NOP;
    req.port_address <= '0;
    req.write_data   <= '0;
    req.access_bytes <= '0;
    req.tick_channel <= CH_DAC1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at base zero
    move_base(16'h0000);
    reg_read(OFF_CTRL | 16'd3);
    reg_read(OFF_STATUS);
    reg_read(OFF_UART);
    reg_write(OFF_UART, 32'hffff_ffff, 3'd4);
    reg_write(OFF_CTRL, 32'hffff_ffff, 3'd0);  // zero size masks every byte
    reg_write(OFF_CTRL, 32'h0000_0070, 3'd4);
    reg_write(OFF_SCTRL, 32'h0000_0700, 3'd7); // oversized access acts as four bytes
    reg_write(OFF_SCNT0, 32'hffff_0003, 3'd4);
    reg_write(OFF_PAGE, {28'd0, PAGE_DAC}, 3'd4);
    reg_write(WIN_ADDR_A, 32'hffff_fffc, 3'd4);
    reg_write(WIN_CNT_A, 32'h0000_0003, 3'd4);
    tick(CH_DAC1);
    tick(CH_DAC1);
    reg_read(WIN_CNT_A);
    tick(CH_DAC2);
    reg_write(OFF_PAGE, {28'd0, PAGE_ADC}, 3'd4);
    reg_write(WIN_ADDR_B, 32'hffff_ffff, 3'd4); // phantom frame register
    reg_read(WIN_ADDR_B);
    tick(CH_ALIAS);                            // channel three runs the adc
    tick(CH_ADC);
    send_word(ACT_NOP, 16'hffff, 32'hffff_ffff, 3'd7, CH_ALIAS);
    reg_write(OFF_SCTRL, 32'h0, 3'd4);         // falling enables clear status bits
    reg_read(OFF_STATUS | 16'd2);
    reg_read(OFF_HOLE);
    reg_write(OFF_HOLE, $urandom, 3'd4);

    bases = '{16'hffff, 16'h0000, 16'($urandom), 16'($urandom)};
    for (int p = 0; p < 4; p++) begin
      move_base(bases[p]);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if (p == 3 && i == WORDS_PER_PHASE - 150) calm <= 1'b1;
        random_word();
      end
    end
    req.valid <= 1'b0;

    // drain, then let the pipeline settle
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
